@@ hdl/rc4_pkg.sv @@
`default_nettype none

package rc4_pkg;

   localparam int SBOX_DEPTH = 256;
   localparam int BYTE_W     = 8;

   localparam logic KIND_KEY  = 1'b0;
   localparam logic KIND_DATA = 1'b1;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_D_J  = 9'b000000010,
      ST_D_WI = 9'b000000100,
      ST_D_WJ = 9'b000001000,
      ST_D_OUT = 9'b000010000,
      ST_K_RD = 9'b000100000,
      ST_K_J  = 9'b001000000,
      ST_K_WK = 9'b010000000,
      ST_K_WJ = 9'b100000000
   } state_type;

endpackage

`default_nettype wire

@@ hdl/rc4_keystream_cipher.sv @@
`default_nettype none

// Channel   Direction  Ports                                  Handshake
// request   in         req_kind, req_value, req_last          req_valid / req_ready
// response  out        rsp_data_out                           rsp_valid / rsp_ready
//
// Key bytes not flagged last are stored and accepted back to back; the last key
// byte runs the key schedule, ST_K_RD and then ST_K_J, ST_K_WK and ST_K_WJ per
// sbox entry. A data byte runs ST_D_J, ST_D_WI, ST_D_WJ and ST_D_OUT; the sbox
// memory has one read and one write port, so dependent reads and swap writes queue.
// Reset restores the identity sbox at once through per-entry valid bits.
// A result waiting on rsp_ready does not block the next accept; only the
// following result holds in its last step until the output register frees.

module rc4_keystream_cipher #(
   parameter int KEY_MAX_BYTES = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_kind,
   input  wire logic [7:0] req_value,
   input  wire logic       req_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_data_out
);

   localparam int KA_W = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
   localparam int KC_W = $clog2(KEY_MAX_BYTES + 1);
   localparam int SA_W = $clog2(rc4_pkg::SBOX_DEPTH);
   localparam int BW   = rc4_pkg::BYTE_W;

   rc4_pkg::state_type state_ff, state_in;

   logic [SA_W-1:0] i_ff, i_in;
   logic [SA_W-1:0] j_ff, j_in;
   logic [BW-1:0]   held_ff, held_in;
   logic [BW-1:0]   sj_ff, sj_in;
   logic [BW-1:0]   value_ff, value_in;
   logic [KA_W-1:0] kidx_ff, kidx_in;
   logic [KC_W-1:0] key_count_ff, key_count_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0]   rsp_data_ff, rsp_data_in;

   // sbox memory with reset-to-identity valid bits
   logic [BW-1:0]   sbox_mem [rc4_pkg::SBOX_DEPTH];
   logic [rc4_pkg::SBOX_DEPTH-1:0] sb_valid_ff;
   logic            sb_we, sb_re, sb_clr;
   logic [SA_W-1:0] sb_waddr, sb_raddr;
   logic [BW-1:0]   sb_wdata;
   logic [BW-1:0]   sb_mem_q_ff;
   logic [SA_W-1:0] sb_addr_q_ff;
   logic            sb_vld_q_ff;
   logic            sb_byp_ff;
   logic [BW-1:0]   sb_byp_data_ff;
   logic [BW-1:0]   sb_rd;

   // key store memory
   logic [BW-1:0]   key_mem [KEY_MAX_BYTES];
   logic            ks_we;
   logic [KA_W-1:0] ks_raddr;
   logic [BW-1:0]   ks_q_ff;

   logic            accept;
   logic            out_free;
   logic [BW-1:0]   key_byte;
   logic [KA_W-1:0] kidx_next;
   logic [SA_W-1:0] sum_j;

   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == rc4_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;

   assign sb_rd    = sb_byp_ff ? sb_byp_data_ff : (sb_vld_q_ff ? sb_mem_q_ff : sb_addr_q_ff);
   assign key_byte = (key_count_ff == '0) ? '0 : ks_q_ff;

   // wrap the key index at the stored key length
   always_comb begin
      if ((KC_W + 1)'(kidx_ff) + (KC_W + 1)'(1) == (KC_W + 1)'(key_count_ff)) begin
         kidx_next = '0;
      end else begin
         kidx_next = kidx_ff + KA_W'(1);
      end
   end

   assign sum_j = j_ff + sb_rd + ((state_ff == rc4_pkg::ST_K_J) ? key_byte : '0);

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      held_in      = held_ff;
      sj_in        = sj_ff;
      value_in     = value_ff;
      kidx_in      = kidx_ff;
      key_count_in = key_count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      sb_we        = 1'b0;
      sb_waddr     = i_ff;
      sb_wdata     = sj_ff;
      sb_re        = 1'b0;
      sb_raddr     = i_ff + SA_W'(1);
      sb_clr       = 1'b0;
      ks_we        = 1'b0;
      ks_raddr     = kidx_ff;

      unique case (state_ff)
         rc4_pkg::ST_IDLE: begin
            // prefetch S[i+1] for the next data byte
            sb_re = 1'b1;
            if (accept) begin
               if (req_kind == rc4_pkg::KIND_DATA) begin
                  i_in     = i_ff + SA_W'(1);
                  value_in = req_value;
                  state_in = rc4_pkg::ST_D_J;
               end else begin
                  if (key_count_ff < KC_W'(KEY_MAX_BYTES)) begin
                     ks_we        = 1'b1;
                     key_count_in = key_count_ff + KC_W'(1);
                  end
                  if (req_last) begin
                     sb_clr   = 1'b1;
                     i_in     = '0;
                     j_in     = '0;
                     kidx_in  = '0;
                     state_in = rc4_pkg::ST_K_RD;
                  end
               end
            end
         end
         rc4_pkg::ST_D_J: begin
            held_in  = sb_rd;
            j_in     = sum_j;
            sb_re    = 1'b1;
            sb_raddr = sum_j;
            state_in = rc4_pkg::ST_D_WI;
         end
         rc4_pkg::ST_D_WI: begin
            sj_in    = sb_rd;
            sb_we    = 1'b1;
            sb_waddr = i_ff;
            sb_wdata = sb_rd;
            state_in = rc4_pkg::ST_D_WJ;
         end
         rc4_pkg::ST_D_WJ: begin
            sb_we    = 1'b1;
            sb_waddr = j_ff;
            sb_wdata = held_ff;
            sb_re    = 1'b1;
            sb_raddr = held_ff + sj_ff;
            state_in = rc4_pkg::ST_D_OUT;
         end
         rc4_pkg::ST_D_OUT: begin
            // hold until the output register frees
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = value_ff ^ sb_rd;
               state_in     = rc4_pkg::ST_IDLE;
            end
         end
         rc4_pkg::ST_K_RD: begin
            sb_re    = 1'b1;
            sb_raddr = i_ff;
            state_in = rc4_pkg::ST_K_J;
         end
         rc4_pkg::ST_K_J: begin
            held_in  = sb_rd;
            j_in     = sum_j;
            sb_re    = 1'b1;
            sb_raddr = sum_j;
            state_in = rc4_pkg::ST_K_WK;
         end
         rc4_pkg::ST_K_WK: begin
            sb_we    = 1'b1;
            sb_waddr = i_ff;
            sb_wdata = sb_rd;
            state_in = rc4_pkg::ST_K_WJ;
         end
         rc4_pkg::ST_K_WJ: begin
            sb_we    = 1'b1;
            sb_waddr = j_ff;
            sb_wdata = held_ff;
            if (i_ff == SA_W'(rc4_pkg::SBOX_DEPTH - 1)) begin
               i_in         = '0;
               j_in         = '0;
               key_count_in = '0;
               state_in     = rc4_pkg::ST_IDLE;
            end else begin
               // overlap the next entry's reads with this write
               i_in     = i_ff + SA_W'(1);
               kidx_in  = kidx_next;
               ks_raddr = kidx_next;
               sb_re    = 1'b1;
               sb_raddr = i_ff + SA_W'(1);
               state_in = rc4_pkg::ST_K_J;
            end
         end
         default: begin
            state_in = rc4_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rc4_pkg::ST_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         kidx_ff      <= '0;
         key_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         kidx_ff      <= kidx_in;
         key_count_ff <= key_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff     <= held_in;
      sj_ff       <= sj_in;
      value_ff    <= value_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset || sb_clr) begin
         sb_valid_ff <= '0;
      end else if (sb_we) begin
         sb_valid_ff[sb_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (sb_we) begin
         sbox_mem[sb_waddr] <= sb_wdata;
      end
      if (sb_re) begin
         sb_mem_q_ff    <= sbox_mem[sb_raddr];
         sb_addr_q_ff   <= sb_raddr;
         sb_vld_q_ff    <= sb_valid_ff[sb_raddr];
         sb_byp_ff      <= sb_we && (sb_waddr == sb_raddr);
         sb_byp_data_ff <= sb_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ks_we) begin
         key_mem[key_count_ff[KA_W-1:0]] <= req_value;
      end
      ks_q_ff <= key_mem[ks_raddr];
   end

   a_sched_blocks: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == rc4_pkg::KIND_KEY && req_last) |=> !req_ready)
      else $error("key schedule did not block the request channel");

   a_out_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rc4_pkg::ST_D_OUT && out_free) |=> (rsp_valid && req_ready))
      else $error("data byte result not delivered to the output register");

   a_key_bound: assert property (@(posedge clock) disable iff (reset)
      key_count_ff <= KC_W'(KEY_MAX_BYTES))
      else $error("key count past the key store depth");

   a_sched_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rc4_pkg::ST_K_WJ && state_in == rc4_pkg::ST_IDLE)
      |=> (key_count_ff == '0 && i_ff == '0 && j_ff == '0))
      else $error("indices or key count not cleared after key schedule");

endmodule

`default_nettype wire

@@ tb/sv/tb_rc4_keystream_cipher.sv @@
`default_nettype none

module tb_rc4_keystream_cipher;

   localparam int KEY_LIMIT    = 256;
   localparam int RANDOM_ITEMS = 150;
   // longest key schedule plus a few data steps
   localparam int DRAIN_CYCLES = 800;
   localparam int LIMIT_CYCLES = 2000000;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_kind;
   logic [7:0] req_value;
   logic       req_last;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_data_out;

   rc4_keystream_cipher #(
      .KEY_MAX_BYTES(KEY_LIMIT)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_kind     (req_kind),
      .req_value    (req_value),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data_out (rsp_data_out)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // cipher state as the block should hold it
   logic [7:0] sbox_model [rc4_pkg::SBOX_DEPTH];
   logic [7:0] key_bytes [rc4_pkg::SBOX_DEPTH];
   int         key_len;
   logic [7:0] gen_i;
   logic [7:0] gen_j;

   logic [7:0] expected_bytes [$];
   int         error_count = 0;
   int         items_sent = 0;
   int         burst_left = 0;

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      $display("MISMATCH %s: got %02h expected %02h at %0t", what, got, want, $time);
      error_count++;
   endtask

   task automatic run_key_schedule();
      logic [7:0] j;
      logic [7:0] t;
      int         len;
      j   = 8'd0;
      len = key_len;
      if (len == 0) begin
         len          = 1;
         key_bytes[0] = 8'd0;
      end
      for (int k = 0; k < rc4_pkg::SBOX_DEPTH; k++)
         sbox_model[k] = k[7:0];
      for (int k = 0; k < rc4_pkg::SBOX_DEPTH; k++) begin
         j             = j + sbox_model[k] + key_bytes[k % len];
         t             = sbox_model[k];
         sbox_model[k] = sbox_model[j];
         sbox_model[j] = t;
      end
      gen_i   = 8'd0;
      gen_j   = 8'd0;
      key_len = 0;
   endtask

   task automatic store_key_byte(logic [7:0] value, logic lst);
      if (key_len < KEY_LIMIT) begin
         key_bytes[key_len] = value;
         key_len++;
      end
      if (lst)
         run_key_schedule();
   endtask

   function automatic logic [7:0] next_keystream();
      logic [7:0] t;
      logic [7:0] idx;
      gen_i             = gen_i + 8'd1;
      gen_j             = gen_j + sbox_model[gen_i];
      t                 = sbox_model[gen_i];
      sbox_model[gen_i] = sbox_model[gen_j];
      sbox_model[gen_j] = t;
      idx               = sbox_model[gen_i] + sbox_model[gen_j];
      return sbox_model[idx];
   endfunction

   // drive one item in bursts with random gaps between them
   task automatic send_byte(logic kind, logic [7:0] value, logic lst);
      logic [7:0] ks;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_value <= value;
      req_last  <= lst;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      items_sent++;
      if (kind == rc4_pkg::KIND_KEY) begin
         store_key_byte(value, lst);
      end else begin
         ks = next_keystream();
         expected_bytes.push_back(value ^ ks);
      end
   endtask

   task automatic send_key(int len);
      for (int k = 0; k < len; k++)
         send_byte(rc4_pkg::KIND_KEY, 8'($urandom), k == len - 1);
   endtask

   task automatic send_data(int count);
      for (int k = 0; k < count; k++)
         send_byte(rc4_pkg::KIND_DATA, 8'($urandom), 1'($urandom));
   endtask

   // identity sbox after reset; last flag on data must be ignored
   task automatic test_data_without_key();
      send_byte(rc4_pkg::KIND_DATA, 8'h00, 1'b0);
      send_byte(rc4_pkg::KIND_DATA, 8'hFF, 1'b1);
      send_byte(rc4_pkg::KIND_DATA, 8'hA5, 1'b0);
      send_byte(rc4_pkg::KIND_DATA, 8'h5A, 1'b1);
   endtask

   task automatic test_single_byte_key();
      send_byte(rc4_pkg::KIND_KEY, 8'hFF, 1'b1);
      send_byte(rc4_pkg::KIND_DATA, 8'h00, 1'b0);
      send_byte(rc4_pkg::KIND_DATA, 8'hFF, 1'b0);
      send_byte(rc4_pkg::KIND_KEY, 8'h00, 1'b1);
      send_byte(rc4_pkg::KIND_DATA, 8'h80, 1'b0);
      send_byte(rc4_pkg::KIND_DATA, 8'h01, 1'b1);
   endtask

   // bytes past the limit are dropped, but their last flag still counts
   task automatic test_key_overflow();
      for (int k = 0; k < KEY_LIMIT + 4; k++)
         send_byte(rc4_pkg::KIND_KEY, 8'($urandom), k == KEY_LIMIT + 3);
      send_data(6);
   endtask

   // same key twice must give the same keystream again
   task automatic test_rekey_after_data();
      logic [7:0] key [5] = '{8'h01, 8'h23, 8'h45, 8'h67, 8'h89};
      for (int r = 0; r < 2; r++) begin
         for (int k = 0; k < 5; k++)
            send_byte(rc4_pkg::KIND_KEY, key[k], k == 4);
         send_byte(rc4_pkg::KIND_DATA, 8'h00, 1'b0);
         send_byte(rc4_pkg::KIND_DATA, 8'hFF, 1'b0);
         send_data(3);
      end
   endtask

   task automatic test_random_traffic();
      int stop_at;
      int pick;
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
               send_key($urandom_range(1, 16));
            else if (pick < 95)
               send_key($urandom_range(17, 64));
            else
               send_key($urandom_range(200, KEY_LIMIT + 3));
            send_data($urandom_range(1, 30));
         end else begin
            // loose items: stray key bytes and data with the last flag
            repeat ($urandom_range(1, 5))
               send_byte(1'($urandom), 8'($urandom), $urandom_range(0, 5) == 0);
         end
      end
   endtask

   always @(posedge clock) begin : rsp_check
      int         mode;
      int         cycle;
      logic [7:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch("result with none pending", rsp_data_out, 8'h00);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_data_out !== want)
               report_mismatch("data_out", rsp_data_out, want);
         end
      end
      // switch the stall pattern among always ready, random and mostly stalled
      if (cycle % 50 == 0)
         mode = $urandom_range(0, 2);
      cycle++;
      case (mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom);
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   initial begin
      for (int k = 0; k < rc4_pkg::SBOX_DEPTH; k++)
         sbox_model[k] = k[7:0];
      key_len   = 0;
      gen_i     = 8'd0;
      gen_j     = 8'd0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_kind  <= rc4_pkg::KIND_KEY;
      req_value <= 8'h00;
      req_last  <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_data_without_key();
      test_single_byte_key();
      test_rekey_after_data();
      test_key_overflow();
      test_random_traffic();

      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #(20 * LIMIT_CYCLES);
      $display("TIMEOUT at %0t", $time);
      $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
hdl/rc4_pkg.sv
hdl/rc4_keystream_cipher.sv
tb/sv/tb_rc4_keystream_cipher.sv
